@@ hw/rtl/lir_pkg.sv @@
// lir_pkg: shared types and constants of the linear interpolation resampler
// used by lir_ctrl, lir_dp and linear_interp_resampler; no dependencies
`default_nettype none

package lir_pkg;

	// configuration port
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 20;
	localparam logic [CFG_IDX_W-1:0] CFG_STEP_INCREMENT = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_START_PHASE    = 2'd1;

	// register widths
	localparam int STEP_W  = 20;
	localparam int START_W = 12;
	localparam logic [STEP_W-1:0] STEP_RESET = 20'd4096;

	// source samples still to arrive before the next output
	localparam int SKIP_W = 8;
	localparam logic [SKIP_W-1:0] SKIP_INIT = 8'd2;
	localparam logic [SKIP_W-1:0] SKIP_MAX  = 8'd255;

	// longest burst of outputs for one input word
	localparam int MAX_RUN = 64;
	localparam int RUN_W   = $clog2(MAX_RUN);

	typedef struct packed {
		logic shift;  // input word taken, slide the window
		logic mul;    // load the product register
		logic emit;   // load the output register, advance phase
	} dp_cmd_t;

	typedef struct packed {
		logic skip_le1;  // window reaches the position after this shift
		logic carry_nz;  // next phase step moves past the current window
	} dp_stat_t;

endpackage

`default_nettype wire

@@ hw/rtl/linear_interp_resampler.sv @@
// linear_interp_resampler: top level of the streaming linear interpolation resampler
// depends on lir_pkg, lir_ctrl and lir_dp
`default_nettype none

// Streaming linear-interpolation sample-rate converter. Each input word slides a
// two-sample window; while the window covers the current position the block emits
// left + floor((right - left) * phase / 2^FRAC_BITS), then adds step_increment to
// the phase and skips as many input words as the integer carry says (saturating at
// 255). Outputs caused by one input form a burst of at most 64 words, and the final
// one carries last_of_run. An input word that causes outputs holds off the next input
// until its burst is done, since every output goes through the registered multiplier
// and then the interpolation adder into the output register. The output register lets
// the next input be taken while the last word of a burst waits. Writing start_phase
// restarts the stream (window cleared, two inputs needed before the first output);
// step_increment applies from the next output. Configuration writes are taken every
// cycle and belong to idle periods.
module linear_interp_resampler #(
	parameter int FRAC_BITS   = 12,
	parameter int SAMPLE_BITS = 24
) (
	input  wire                             clk,
	input  wire                             arst_n,
	input  wire                             cfg_valid,
	output logic                            cfg_ready,
	input  wire  [lir_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  wire  [lir_pkg::CFG_DATA_W-1:0]  cfg_data,
	input  wire                             in_valid,
	output logic                            in_ready,
	input  wire  signed [SAMPLE_BITS-1:0]   in_sample,
	output logic                            out_valid,
	input  wire                             out_ready,
	output logic signed [SAMPLE_BITS-1:0]   out_sample,
	output logic                            last_of_run
);
	import lir_pkg::*;

	dp_cmd_t  cmd;
	dp_stat_t stat;

	assign cfg_ready = 1'b1;

	lir_ctrl u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.last_of_run (last_of_run),
		.stat        (stat),
		.cmd         (cmd)
	);

	lir_dp #(
		.FRAC_BITS   (FRAC_BITS),
		.SAMPLE_BITS (SAMPLE_BITS)
	) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_valid  (cfg_valid),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.in_sample  (in_sample),
		.cmd        (cmd),
		.stat       (stat),
		.out_sample (out_sample)
	);

endmodule

`default_nettype wire

@@ hw/rtl/lir_dp.sv @@
// lir_dp: window, phase, multiplier and output registers of the resampler
// depends on lir_pkg; driven by lir_ctrl through dp_cmd_t
`default_nettype none

module lir_dp #(
	parameter int FRAC_BITS   = 12,
	parameter int SAMPLE_BITS = 24
) (
	input  wire                             clk,
	input  wire                             arst_n,
	input  wire                             cfg_valid,
	input  wire  [lir_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  wire  [lir_pkg::CFG_DATA_W-1:0]  cfg_data,
	input  wire  [SAMPLE_BITS-1:0]          in_sample,
	input  wire  lir_pkg::dp_cmd_t          cmd,
	output lir_pkg::dp_stat_t               stat,
	output logic [SAMPLE_BITS-1:0]          out_sample
);
	import lir_pkg::*;

	localparam int DIFF_W  = SAMPLE_BITS + 1;
	localparam int PROD_W  = DIFF_W + FRAC_BITS + 1;
	localparam int ACC_W   = ((STEP_W > FRAC_BITS) ? STEP_W : FRAC_BITS) + 1;
	localparam int CARRY_W = ACC_W - FRAC_BITS;

	logic [STEP_W-1:0]             step_q;
	logic signed [SAMPLE_BITS-1:0] left_q;
	logic signed [SAMPLE_BITS-1:0] right_q;
	logic [FRAC_BITS-1:0]          phase_q;
	logic [SKIP_W-1:0]             skip_q;
	logic signed [PROD_W-1:0]      prod_s1;
	logic [SAMPLE_BITS-1:0]        out_q;

	logic signed [DIFF_W-1:0]      diff;
	logic signed [PROD_W-1:0]      interp;
	logic [ACC_W-1:0]              acc;
	logic [CARRY_W-1:0]            carry;
	logic [SKIP_W-1:0]             skip_next;

	logic cfg_step_wr;
	logic cfg_start_wr;

	assign cfg_step_wr  = cfg_valid && (cfg_index == CFG_STEP_INCREMENT);
	assign cfg_start_wr = cfg_valid && (cfg_index == CFG_START_PHASE);

	assign diff = DIFF_W'(right_q) - DIFF_W'(left_q);

	// floor of the scaled product, then offset from the left sample
	assign interp = (prod_s1 >>> FRAC_BITS) + PROD_W'(left_q);

	assign acc   = ACC_W'(phase_q) + ACC_W'(step_q);
	assign carry = acc[ACC_W-1:FRAC_BITS];
	assign skip_next = (32'(carry) > 32'(SKIP_MAX)) ? SKIP_MAX : SKIP_W'(carry);

	assign stat.skip_le1 = (skip_q <= SKIP_W'(1));
	assign stat.carry_nz = (carry != '0);

	assign out_sample = out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q  <= STEP_RESET;
			left_q  <= '0;
			right_q <= '0;
			phase_q <= '0;
			skip_q  <= SKIP_INIT;
		end else begin
			if (cfg_step_wr) begin
				step_q <= cfg_data[STEP_W-1:0];
			end
			if (cfg_start_wr) begin
				// restart the stream at the new fractional position
				phase_q <= FRAC_BITS'(cfg_data[START_W-1:0]);
				left_q  <= '0;
				right_q <= '0;
				skip_q  <= SKIP_INIT;
			end else if (cmd.shift) begin
				left_q  <= right_q;
				right_q <= in_sample;
				if (skip_q != '0) begin
					skip_q <= skip_q - SKIP_W'(1);
				end
			end else if (cmd.emit) begin
				phase_q <= acc[FRAC_BITS-1:0];
				skip_q  <= skip_next;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (cmd.mul) begin
			prod_s1 <= PROD_W'(diff) * PROD_W'(signed'({1'b0, phase_q}));
		end
		if (cmd.emit) begin
			out_q <= interp[SAMPLE_BITS-1:0];
		end
	end

endmodule

`default_nettype wire

@@ hw/rtl/lir_ctrl.sv @@
// lir_ctrl: state machine sequencing input words and output bursts
// depends on lir_pkg; commands lir_dp, owns the output valid and last flag
`default_nettype none

module lir_ctrl (
	input  wire                clk,
	input  wire                arst_n,
	input  wire                in_valid,
	output logic               in_ready,
	output logic               out_valid,
	input  wire                out_ready,
	output logic               last_of_run,
	input  wire  lir_pkg::dp_stat_t stat,
	output lir_pkg::dp_cmd_t   cmd
);
	import lir_pkg::*;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_MUL,
		ST_EMIT
	} state_t;

	state_t           state_q;
	logic [RUN_W-1:0] run_cnt_q;
	logic             out_valid_q;
	logic             last_q;
	logic             run_last;
	logic             slot_free;

	assign slot_free = !out_valid_q || out_ready;
	// burst ends when the window must move or the cap is hit
	assign run_last  = stat.carry_nz || (run_cnt_q == {RUN_W{1'b1}});

	assign in_ready    = (state_q == ST_IDLE);
	assign out_valid   = out_valid_q;
	assign last_of_run = last_q;

	assign cmd.shift = (state_q == ST_IDLE) && in_valid;
	assign cmd.mul   = (state_q == ST_MUL);
	assign cmd.emit  = (state_q == ST_EMIT) && slot_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			run_cnt_q   <= '0;
			out_valid_q <= 1'b0;
			last_q      <= 1'b0;
		end else begin
			if (cmd.emit) begin
				out_valid_q <= 1'b1;
				last_q      <= run_last;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end

			unique case (state_q)
				ST_IDLE: begin
					if (in_valid && stat.skip_le1) begin
						state_q <= ST_MUL;
					end
				end
				ST_MUL: begin
					state_q <= ST_EMIT;
				end
				ST_EMIT: begin
					if (slot_free) begin
						if (run_last) begin
							state_q   <= ST_IDLE;
							run_cnt_q <= '0;
						end else begin
							state_q   <= ST_MUL;
							run_cnt_q <= run_cnt_q + RUN_W'(1);
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	a_emit_slot_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit |-> (!out_valid_q || out_ready))
		else $error("output word overwritten before it was taken");

	a_last_returns_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.emit && run_last) |=> (in_ready && last_q && out_valid_q))
		else $error("burst end did not reopen the input");

	a_idle_run_clear: assert property (@(posedge clk) disable iff (!arst_n)
		in_ready |-> (run_cnt_q == '0))
		else $error("burst counter not cleared while idle");

	a_mul_then_emit: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.mul |=> (state_q == ST_EMIT))
		else $error("product not followed by output stage");

endmodule

`default_nettype wire

@@ sim/linear_interp_resampler_test.sv @@
// linear_interp_resampler_test: self-checking bench for the linear interpolation resampler
// drives source words and register writes, predicts every interpolated word and checks it
// depends on lir_pkg and linear_interp_resampler
`default_nettype none

module linear_interp_resampler_test;
	timeunit 1ns;
	timeprecision 1ps;

	import lir_pkg::*;

	localparam int SAMPLE_W    = 24;
	localparam int FRAC_W      = 12;
	localparam int HOLD_CYCLES = 200;
	localparam int DOG_LIMIT   = 2000;
	localparam int SETTLE_CYC  = 8;

	localparam logic signed [SAMPLE_W-1:0] SMP_MAX = 24'sh7FFFFF;
	localparam logic signed [SAMPLE_W-1:0] SMP_MIN = 24'sh800000;
	localparam logic [STEP_W-1:0] STEP_TOP = 20'd1044480;
	localparam logic [STEP_W-1:0] STEP_LOW = 20'd64;
	localparam logic [START_W-1:0] PHASE_TOP = 12'd4095;

	// indexes past the register list, the block must ignore them
	localparam logic [CFG_IDX_W-1:0] CFG_SPARE_A = 2'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_SPARE_B = 2'd3;

	typedef struct packed {
		logic signed [SAMPLE_W-1:0] smp;
		logic                       is_last;
	} out_word_t;

	typedef enum logic {ROW_WORD, ROW_REG} row_kind_t;

	typedef struct packed {
		row_kind_t                  kind;
		logic [CFG_IDX_W-1:0]       idx;
		logic [CFG_DATA_W-1:0]      data;
		logic signed [SAMPLE_W-1:0] smp;
		logic                       fixed;
		out_word_t                  want;
	} row_t;

	logic clk;
	logic arst_n;
	logic cfg_valid;
	logic cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;
	logic in_valid;
	logic in_ready;
	logic signed [SAMPLE_W-1:0] in_sample;
	logic out_valid;
	logic out_ready;
	logic signed [SAMPLE_W-1:0] out_sample;
	logic last_of_run;

	linear_interp_resampler #(
		.FRAC_BITS  (FRAC_W),
		.SAMPLE_BITS(SAMPLE_W)
	) dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.in_sample  (in_sample),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.out_sample (out_sample),
		.last_of_run(last_of_run)
	);

	// predicted resampler state
	logic [STEP_W-1:0] step_reg;
	logic [FRAC_W-1:0] cur_phase;
	longint win_left;
	longint win_right;
	int skip_left;

	out_word_t pending_q[$];
	int errors;
	int stall_cycles;
	bit eager;
	bit hold_off;

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	task automatic flag_mismatch(input string what, input longint got, input longint want);
		$display("%0t mismatch %s: got %0d, want %0d", $realtime, what, got, want);
		errors++;
	endtask

	// slide the window by one source word and list the interpolated words it releases
	function automatic void interpolate_run(input logic signed [SAMPLE_W-1:0] s,
		ref out_word_t run[$]);
		longint prod;
		longint res;
		int unsigned acc;
		out_word_t w;
		run = {};
		win_left = win_right;
		win_right = longint'(s);
		if (skip_left > 0)
			skip_left--;
		while (skip_left == 0 && run.size() < MAX_RUN) begin
			prod = (win_right - win_left) * longint'(cur_phase);
			res = win_left + (prod >>> FRAC_W);
			w.smp = res[SAMPLE_W-1:0];
			w.is_last = 1'b0;
			run.push_back(w);
			acc = 32'(cur_phase) + 32'(step_reg);
			cur_phase = acc[FRAC_W-1:0];
			skip_left = (acc >> FRAC_W) > SKIP_MAX ? int'(SKIP_MAX) : int'(acc >> FRAC_W);
		end
		if (run.size() > 0)
			run[run.size()-1].is_last = 1'b1;
	endfunction

	function automatic logic signed [SAMPLE_W-1:0] next_source_word(
		input logic signed [SAMPLE_W-1:0] prev);
		case ($urandom_range(0, 7))
			0: return SMP_MAX;
			1: return SMP_MIN;
			2, 3: return SAMPLE_W'(int'(prev) + int'($urandom_range(0, 200)) - 100);
			default: return SAMPLE_W'($urandom());
		endcase
	endfunction

	// stop offering, wait for every expected word, then let the pipeline go quiet
	task automatic settle();
		@(negedge clk);
		in_valid = 1'b0;
		while (pending_q.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYC) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
		settle();
		@(negedge clk);
		cfg_valid = 1'b1;
		cfg_index = idx;
		cfg_data = data;
		do @(posedge clk); while (!cfg_ready);
		case (idx)
			CFG_STEP_INCREMENT: step_reg = data[STEP_W-1:0];
			CFG_START_PHASE: begin
				cur_phase = data[FRAC_W-1:0];
				win_left = 0;
				win_right = 0;
				skip_left = int'(SKIP_INIT);
			end
			default: ;
		endcase
		@(negedge clk);
		cfg_valid = 1'b0;
	endtask

	task automatic send_word(input logic signed [SAMPLE_W-1:0] s, input logic fixed,
		input out_word_t want);
		int gap;
		out_word_t run[$];
		gap = eager ? 0 : int'($urandom_range(0, 3));
		@(negedge clk);
		if (gap > 0) begin
			in_valid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid = 1'b1;
		in_sample = s;
		do @(posedge clk); while (!in_ready);
		interpolate_run(s, run);
		if (fixed)
			pending_q.push_back(want);
		else
			foreach (run[i]) pending_q.push_back(run[i]);
	endtask

	function automatic row_t sample_row(input logic signed [SAMPLE_W-1:0] s);
		row_t r;
		r = '0;
		r.kind = ROW_WORD;
		r.smp = s;
		return r;
	endfunction

	function automatic row_t checked_row(input logic signed [SAMPLE_W-1:0] s,
		input logic signed [SAMPLE_W-1:0] want_smp, input logic want_last);
		row_t r;
		r = sample_row(s);
		r.fixed = 1'b1;
		r.want.smp = want_smp;
		r.want.is_last = want_last;
		return r;
	endfunction

	function automatic row_t reg_row(input logic [CFG_IDX_W-1:0] idx,
		input logic [CFG_DATA_W-1:0] data);
		row_t r;
		r = '0;
		r.kind = ROW_REG;
		r.idx = idx;
		r.data = data;
		return r;
	endfunction

	// receiver: random back-pressure, plus one long hold-off on request
	initial begin
		int gap;
		bit held;
		held = 1'b0;
		out_ready = 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			@(negedge clk);
			if (hold_off && !held) begin
				out_ready = 1'b0;
				repeat (HOLD_CYCLES) @(negedge clk);
				held = 1'b1;
			end
			gap = eager ? 0 : int'($urandom_range(0, 3));
			if (gap > 0) begin
				out_ready = 1'b0;
				repeat (gap) @(negedge clk);
			end
			out_ready = 1'b1;
			do @(posedge clk); while (!out_valid);
		end
	end

	always @(posedge clk) begin : check_out
		out_word_t want;
		if (arst_n && out_valid && out_ready) begin
			if (pending_q.size() == 0) begin
				flag_mismatch("unexpected word", longint'(out_sample), 0);
			end else begin
				want = pending_q.pop_front();
				if (out_sample !== want.smp)
					flag_mismatch("out_sample", longint'(out_sample), longint'(want.smp));
				if (last_of_run !== want.is_last)
					flag_mismatch("last_of_run", longint'(last_of_run),
						longint'(want.is_last));
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (in_valid && in_ready) || (out_valid && out_ready)
			|| (cfg_valid && cfg_ready))
			stall_cycles <= 0;
		else
			stall_cycles <= stall_cycles + 1;
		if (stall_cycles == DOG_LIMIT) begin
			$display("FAIL linear_interp_resampler");
			$finish;
		end
	end

	initial begin
		row_t plan[$];
		logic [STEP_W-1:0] step;
		logic [CFG_DATA_W-1:0] start;
		logic signed [SAMPLE_W-1:0] src;
		int count;

		arst_n = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		in_valid = 1'b0;
		in_sample = '0;
		eager = 1'b0;
		hold_off = 1'b0;
		step_reg = STEP_RESET;
		cur_phase = '0;
		win_left = 0;
		win_right = 0;
		skip_left = int'(SKIP_INIT);
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// window fills after two words, then extremes at phase zero
		plan.push_back(sample_row(24'sd100));
		plan.push_back(checked_row(SMP_MAX, 24'sd100, 1'b1));
		plan.push_back(checked_row(SMP_MIN, SMP_MAX, 1'b1));
		// half step: two words per source, negative products floor downward
		plan.push_back(reg_row(CFG_STEP_INCREMENT, 20'd2048));
		plan.push_back(sample_row(24'sd0));
		plan.push_back(sample_row(SMP_MAX));
		plan.push_back(sample_row(SMP_MIN));
		// start phase with high bits set restarts the stream at the top phase
		plan.push_back(reg_row(CFG_START_PHASE, 20'hFFFFF));
		plan.push_back(sample_row(-24'sd1));
		plan.push_back(checked_row(24'sd1, 24'sd0, 1'b1));
		// zero step: every word gives a capped burst
		plan.push_back(reg_row(CFG_STEP_INCREMENT, 20'd0));
		plan.push_back(sample_row(24'sd5000));
		plan.push_back(sample_row(-24'sd5000));
		plan.push_back(reg_row(CFG_SPARE_A, 20'hFFFFF));
		plan.push_back(reg_row(CFG_SPARE_B, 20'h5A5A5));
		plan.push_back(sample_row(24'sd77));
		// step of 64: bursts of exactly 64, where the carry and the cap end the burst together
		plan.push_back(reg_row(CFG_STEP_INCREMENT, STEP_LOW));
		plan.push_back(reg_row(CFG_START_PHASE, 20'd0));
		plan.push_back(sample_row(24'sh400000));
		plan.push_back(sample_row(-24'sh400000));
		plan.push_back(sample_row(24'sh123456));

		foreach (plan[i]) begin
			if (plan[i].kind == ROW_REG)
				write_reg(plan[i].idx, plan[i].data);
			else
				send_word(plan[i].smp, plan[i].fixed, plan[i].want);
		end

		src = 0;
		for (int ph = 0; ph < 7; ph++) begin
			eager = 1'b0;
			start = CFG_DATA_W'($urandom());
			case (ph)
				0: begin
					step = STEP_W'($urandom_range(64, 4095));
					count = 25;
				end
				1: begin
					step = STEP_W'($urandom_range(4096, 40000));
					count = 25;
					eager = 1'b1;
				end
				2: begin
					step = STEP_W'($urandom_range(64, 300));
					count = 12;
				end
				3: begin
					// carry of 255 sits right at the saturation bound, next word comes 255 sources later
					step = STEP_TOP;
					start = CFG_DATA_W'(PHASE_TOP);
					count = 260;
				end
				4: begin
					step = STEP_W'($urandom());
					count = 20;
				end
				5: begin
					step = '0;
					count = 4;
				end
				default: begin
					step = STEP_W'($urandom_range(64, 8192));
					count = 30;
				end
			endcase
			write_reg(CFG_STEP_INCREMENT, step);
			write_reg(CFG_START_PHASE, start);
			if (ph == 2)
				hold_off = 1'b1;
			for (int i = 0; i < count; i++) begin
				if (ph == 6 && i == 20)
					settle();
				src = next_source_word(src);
				send_word(src, 1'b0, '0);
			end
		end

		settle();
		if (errors == 0 && pending_q.size() == 0)
			$display("PASS linear_interp_resampler");
		else
			$display("FAIL linear_interp_resampler");
		$finish;
	end

endmodule

`default_nettype wire
